[hdl/u2a_pkg.sv]
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types and byte constants for the UTF-8 punctuation transliterator.
// ----------------------------------------------------------------------------
package u2a_pkg;

  // Default depth of the queue between the front and back end
  localparam int unsigned QueueDepthDefault = 2;

  // Lead bytes of recognized sequences
  localparam logic [7:0] ByteE2 = 8'hE2;
  localparam logic [7:0] ByteC2 = 8'hC2;
  localparam logic [7:0] ByteEF = 8'hEF;
  // Continuation bytes
  localparam logic [7:0] Byte80 = 8'h80;
  localparam logic [7:0] ByteBB = 8'hBB;
  localparam logic [7:0] ByteBF = 8'hBF;
  localparam logic [7:0] ByteA0 = 8'hA0;
  localparam logic [7:0] ByteAD = 8'hAD;
  // Third bytes after E2 80
  localparam logic [7:0] ByteDash0   = 8'h90;
  localparam logic [7:0] ByteDash1   = 8'h91;
  localparam logic [7:0] ByteDash2   = 8'h92;
  localparam logic [7:0] ByteDash3   = 8'h93;
  localparam logic [7:0] ByteDash4   = 8'h94;
  localparam logic [7:0] ByteSquo0   = 8'h98;
  localparam logic [7:0] ByteSquo1   = 8'h99;
  localparam logic [7:0] ByteSquo2   = 8'h9A;
  localparam logic [7:0] ByteSquo3   = 8'h9B;
  localparam logic [7:0] ByteDquo0   = 8'h9C;
  localparam logic [7:0] ByteDquo1   = 8'h9D;
  localparam logic [7:0] ByteDquo2   = 8'h9E;
  localparam logic [7:0] ByteDquo3   = 8'h9F;
  localparam logic [7:0] ByteBullet  = 8'hA2;
  localparam logic [7:0] ByteEllip   = 8'hA6;
  localparam logic [7:0] BytePrime   = 8'hB2;
  localparam logic [7:0] ByteDPrime  = 8'hB3;

  // ASCII replacements
  localparam logic [7:0] AsciiApos   = 8'h27;
  localparam logic [7:0] AsciiQuote  = 8'h22;
  localparam logic [7:0] AsciiHyphen = 8'h2D;
  localparam logic [7:0] AsciiDot    = 8'h2E;
  localparam logic [7:0] AsciiStar   = 8'h2A;
  localparam logic [7:0] AsciiSpace  = 8'h20;

  // Work for the back end: up to three output bytes caused by one input byte.
  // cnt == 0 with fin set is an empty end-of-string marker.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            fin;
  } action_t;

endpackage

[hdl/u2a_if.sv]
// ----------------------------------------------------------------------------
// u2a_if
// Valid/ready channels for input bytes and output items.
// ----------------------------------------------------------------------------
interface u2a_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_end;

  modport source (output valid, output in_byte, output in_end, input ready);
  modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

interface u2a_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       end_of_string;
  logic       run_final;

  modport source (output valid, output out_byte, output byte_present,
                  output end_of_string, output run_final, input ready);
  modport sink   (input valid, input out_byte, input byte_present,
                  input end_of_string, input run_final, output ready);
endinterface

[hdl/u2a_front.sv]
// ----------------------------------------------------------------------------
// u2a_front
// Accepts input bytes, holds pending prefix bytes and classifies each byte
// into a list of up to three output bytes for the back end.
// ----------------------------------------------------------------------------
module u2a_front import u2a_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  u2a_in_if.sink     in_i,
  input  logic       full_i,
  output logic       push_o,
  output action_t    act_o
);

  typedef enum logic [1:0] {
    HeadRaw,
    HeadWait,
    HeadMatch
  } head_e;

  typedef struct packed {
    head_e      kind;
    logic [1:0] used;
    logic [1:0] nout;
    logic [7:0] ch;
  } head_t;

  logic [1:0]      cnt_q, cnt_d;
  logic [1:0][7:0] pend_q, pend_d;
  logic            accept;

  // Recognize a sequence at the head of the remaining bytes
  function automatic head_t scan_head(logic [7:0] b0, logic [7:0] b1,
                                      logic [7:0] b2, logic [1:0] rem,
                                      logic fin);
    head_t h;
    h = '{kind: HeadRaw, used: 2'd1, nout: 2'd0, ch: 8'h00};
    case (b0)
      ByteE2: begin
        if (rem >= 2'd2 && b1 != Byte80) begin
          h.kind = HeadRaw;
        end else if (rem < 2'd3) begin
          h.kind = fin ? HeadRaw : HeadWait;
        end else begin
          h.kind = HeadMatch;
          h.used = 2'd3;
          h.nout = 2'd1;
          case (b2)
            ByteSquo0, ByteSquo1, ByteSquo2, ByteSquo3, BytePrime:  h.ch = AsciiApos;
            ByteDquo0, ByteDquo1, ByteDquo2, ByteDquo3, ByteDPrime: h.ch = AsciiQuote;
            ByteDash0, ByteDash1, ByteDash2, ByteDash3, ByteDash4:  h.ch = AsciiHyphen;
            ByteEllip: begin
              h.ch   = AsciiDot;
              h.nout = 2'd3;
            end
            ByteBullet: h.ch = AsciiStar;
            default: begin
              h.kind = HeadRaw;
              h.used = 2'd1;
              h.nout = 2'd0;
            end
          endcase
        end
      end
      ByteC2: begin
        if (rem < 2'd2) begin
          h.kind = fin ? HeadRaw : HeadWait;
        end else if (b1 == ByteA0) begin
          h.kind = HeadMatch;
          h.used = 2'd2;
          h.nout = 2'd1;
          h.ch   = AsciiSpace;
        end else if (b1 == ByteAD) begin
          h.kind = HeadMatch;
          h.used = 2'd2;
        end else begin
          h.kind = HeadRaw;
        end
      end
      ByteEF: begin
        if (rem >= 2'd2 && b1 != ByteBB) begin
          h.kind = HeadRaw;
        end else if (rem >= 2'd3 && b2 != ByteBF) begin
          h.kind = HeadRaw;
        end else if (rem < 2'd3) begin
          h.kind = fin ? HeadRaw : HeadWait;
        end else begin
          h.kind = HeadMatch;
          h.used = 2'd3;
        end
      end
      default: h.kind = HeadRaw;
    endcase
    return h;
  endfunction

  function automatic logic [7:0] pick(logic [2:0][7:0] b, logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = b[0];
      3'd1:    v = b[1];
      3'd2:    v = b[2];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  always_comb begin
    logic [2:0][7:0] buf_b;
    logic [1:0]      n;
    logic [1:0]      pos;
    logic [1:0]      rem;
    logic [1:0]      nres;
    logic            done;
    head_t           h;
    action_t         act;

    buf_b[0] = (cnt_q == 2'd0) ? in_i.in_byte : pend_q[0];
    buf_b[1] = (cnt_q == 2'd2) ? pend_q[1] : in_i.in_byte;
    buf_b[2] = in_i.in_byte;
    n        = cnt_q + 2'd1;
    pos      = 2'd0;
    rem      = 2'd0;
    h        = '{kind: HeadRaw, used: 2'd1, nout: 2'd0, ch: 8'h00};
    nres     = 2'd0;
    done     = 1'b0;
    act      = '0;
    act.fin  = in_i.in_end;
    cnt_d    = 2'd0;
    pend_d   = pend_q;

    // each pass consumes at least one byte, so three passes cover the buffer
    for (int it = 0; it < 3; it++) begin
      if (!done && pos < n) begin
        rem = n - pos;
        h   = scan_head(pick(buf_b, {1'b0, pos}), pick(buf_b, {1'b0, pos} + 3'd1),
                        pick(buf_b, {1'b0, pos} + 3'd2), rem, in_i.in_end);
        case (h.kind)
          HeadWait: begin
            pend_d[0] = pick(buf_b, {1'b0, pos});
            pend_d[1] = pick(buf_b, {1'b0, pos} + 3'd1);
            cnt_d     = rem;
            done      = 1'b1;
          end
          HeadMatch: begin
            for (int j = 0; j < 3; j++) begin
              if (2'(j) < h.nout && nres != 2'd3) begin
                act.bytes[nres] = h.ch;
                nres            = nres + 2'd1;
              end
            end
            pos = pos + h.used;
          end
          default: begin
            if (nres != 2'd3) begin
              act.bytes[nres] = pick(buf_b, {1'b0, pos});
              nres            = nres + 2'd1;
            end
            pos = pos + 2'd1;
          end
        endcase
      end
    end

    act.cnt = nres;
    act_o   = act;
    push_o  = accept && (nres != 2'd0 || in_i.in_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("pending count out of range");

  a_end_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.in_end) |=> (cnt_q == 2'd0))
    else $error("pending bytes left after end of string");

endmodule

[hdl/u2a_queue.sv]
// ----------------------------------------------------------------------------
// u2a_queue
// Small FIFO of actions between the front and back end.
// ----------------------------------------------------------------------------
module u2a_queue import u2a_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  action_t act_i,
  input  logic    pop_i,
  output logic    full_o,
  output logic    head_valid_o,
  output action_t head_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  action_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= act_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue count exceeds depth");

endmodule

[hdl/u2a_back.sv]
// ----------------------------------------------------------------------------
// u2a_back
// Walks action bytes one per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module u2a_back import u2a_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  action_t    head_i,
  output logic       pop_o,
  u2a_out_if.source  out_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       present_q, eos_q, final_q;
  logic       load, last, empty_mark;

  assign load       = head_valid_i && (!valid_q || out_o.ready);
  assign empty_mark = (head_i.cnt == 2'd0);
  assign last       = empty_mark || (idx_q == head_i.cnt - 2'd1);
  assign pop_o      = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last ? 2'd0 : idx_q + 2'd1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q    <= empty_mark ? 8'h00 : head_i.bytes[idx_q];
      present_q <= !empty_mark;
      eos_q     <= head_i.fin && last;
      final_q   <= last;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.out_byte      = byte_q;
  assign out_o.byte_present  = present_q;
  assign out_o.end_of_string = eos_q;
  assign out_o.run_final     = final_q;

  a_idx_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> (head_valid_i && idx_q < head_i.cnt))
    else $error("byte index without a matching queued action");

endmodule

[hdl/utf8_punctuation_to_ascii.sv]
// ----------------------------------------------------------------------------
// utf8_punctuation_to_ascii
// Streaming UTF-8 typographic punctuation to ASCII transliterator.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the action queue is not full. The
// front end holds up to two prefix bytes (E2, E2 80, C2, EF, EF BB) and turns
// each byte into zero to three output items; the back end sends those out one
// item per cycle, unless the output stalls, from a registered output stage. A
// byte that yields one item or none keeps the full rate of one byte per cycle;
// a byte that yields two or three items (ellipsis, broken or flushed prefix)
// holds the back end longer; the action queue (QueueDepth entries) absorbs
// this until the input stalls. Items pass the queue, then the output register.
// ----------------------------------------------------------------------------
module utf8_punctuation_to_ascii import u2a_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault  // 2 or more
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  u2a_in_if.sink    in_i,
  u2a_out_if.source out_o
);

  logic    push, pop, full, head_valid;
  action_t act, head;

  u2a_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .act_o  (act)
  );

  u2a_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .act_i        (act),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  u2a_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
